/* rtl/mpq_pkg.sv */
// mpq_pkg: shared constants and types for the ready queue scheduler
// no dependencies
package mpq_pkg;
	localparam int unsigned QUEUE_DEPTH = 32;
	localparam int unsigned THREADS = 16;
	localparam int unsigned TW = 5;
	localparam int unsigned DW = 16;
	localparam int unsigned VW = 48;
	localparam logic [VW-1:0] VR_MAX = {VW{1'b1}};

	typedef enum logic [1:0] {
		POL_FCFS = 2'd0,
		POL_SJF  = 2'd1,
		POL_PRIO = 2'd2,
		POL_VRT  = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [TW-1:0] thread;
		logic [DW-1:0] index;
		logic [DW-1:0] length;
	} entry_t;
endpackage

/* rtl/multi_policy_ready_queue_scheduler.sv */
// multi_policy_ready_queue_scheduler: ready queue with four dispatch policies
// queue entries and per-thread virtual runtimes live in synchronous memories
// depends on mpq_pkg
//
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   kind thread_id burst_index burst_length
// out      out  out_valid/out_stall status sel_thread sel_index sel_length sel_vruntime
// cfg      in   cfg_we              cfg_wdata (policy)
//
// enqueue: the beat is written in idle and its result is held in the output state.
// dispatch: a scan of every queued entry (queue read, vruntime read, compare), then
// fetch of the chosen entry, multiply and the saturating update, a read and a write
// per entry behind the chosen one for the compaction plus a final check, then the
// output and idle states. one item at a time; the result sits in an output register
// and the next beat is taken once it has been delivered, so result stalls hold it off.
// reset clears control, occupancy and the per-thread valid bits.
module multi_policy_ready_queue_scheduler #(
	parameter int unsigned QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH,
	parameter int unsigned THREADS = mpq_pkg::THREADS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic kind,
	input  logic [4:0] thread_id,
	input  logic [15:0] burst_index,
	input  logic [15:0] burst_length,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] status,
	output logic [4:0] sel_thread,
	output logic [15:0] sel_index,
	output logic [15:0] sel_length,
	output logic [47:0] sel_vruntime
);
	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned HW = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int unsigned VW = mpq_pkg::VW;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_SRD   = 11'b00000000010,
		S_SVR   = 11'b00000000100,
		S_SCMP  = 11'b00000001000,
		S_GET   = 11'b00000010000,
		S_GVR   = 11'b00000100000,
		S_MUL   = 11'b00001000000,
		S_UPD   = 11'b00010000000,
		S_CRD   = 11'b00100000000,
		S_CWR   = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [1:0] policy_q;
	logic [CW-1:0] occ_q;
	logic [CW-1:0] idx_q;
	logic [AW-1:0] best_q;
	logic [VW-1:0] bkey_q;
	logic [THREADS-1:0] vr_valid_q;

	mpq_pkg::entry_t qmem [QUEUE_DEPTH];
	logic [VW-1:0] vmem [THREADS];
	mpq_pkg::entry_t qrd_q;
	logic [VW-1:0] vrd_q;
	logic q_we;
	logic [AW-1:0] q_wa, q_ra;
	mpq_pkg::entry_t q_wd;
	logic v_we;
	logic [HW-1:0] v_wa, v_ra;
	logic [VW-1:0] v_wd;
	logic vrd_ok_q;

	mpq_pkg::entry_t sel_q;
	logic [VW-1:0] vr_q;
	logic [VW:0] add_q;
	logic [1:0] st_q;

	function automatic logic tvalid(input logic [4:0] t);
		return (t >= 5'd1) && ({27'd0, t} <= 32'(THREADS));
	endfunction

	always_ff @(posedge clk) begin
		if (q_we) qmem[q_wa] <= q_wd;
		qrd_q <= qmem[q_ra];
		if (v_we) vmem[v_wa] <= v_wd;
		vrd_q <= vmem[v_ra];
	end

	logic [4:0] cur_t;
	logic [HW-1:0] t_addr;
	assign cur_t = (state_q == S_SVR || state_q == S_GVR) ? qrd_q.thread : sel_q.thread;
	assign t_addr = HW'(cur_t - 5'd1);

	logic [VW-1:0] key;
	always_comb begin
		case (policy_q)
			mpq_pkg::POL_SJF:  key = VW'(qrd_q.length);
			mpq_pkg::POL_PRIO: key = VW'(qrd_q.thread);
			mpq_pkg::POL_VRT:  key = vrd_ok_q ? vrd_q : '0;
			default:           key = '0;
		endcase
	end

	always_comb begin
		q_we = 1'b0;
		q_wa = idx_q[AW-1:0];
		q_wd = qrd_q;
		q_ra = idx_q[AW-1:0];
		v_we = 1'b0;
		v_wa = t_addr;
		v_wd = (vr_q > mpq_pkg::VR_MAX - add_q[VW-1:0]) ? mpq_pkg::VR_MAX
			: VW'(VW'(vr_q) + add_q[VW-1:0]);
		v_ra = t_addr;
		if (state_q == S_IDLE) begin
			q_wa = occ_q[AW-1:0];
			q_wd = '{thread: thread_id, index: burst_index, length: burst_length};
			q_we = in_valid && !in_stall && !kind && (occ_q < CW'(QUEUE_DEPTH));
		end
		if (state_q == S_GET) q_ra = best_q;
		if (state_q == S_CWR) begin
			q_we = 1'b1;
			q_wa = AW'(idx_q - CW'(1));
		end
		if (state_q == S_UPD) v_we = tvalid(sel_q.thread);
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = st_q;
	assign sel_thread = sel_q.thread;
	assign sel_index = sel_q.index;
	assign sel_length = sel_q.length;
	assign sel_vruntime = vr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			policy_q <= 2'd0;
			occ_q <= '0;
			idx_q <= '0;
			best_q <= '0;
			bkey_q <= '0;
			vr_valid_q <= '0;
			vrd_ok_q <= 1'b0;
			sel_q <= '0;
			vr_q <= '0;
			add_q <= '0;
			st_q <= 2'd0;
		end else begin
			if (cfg_we) policy_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sel_q <= '0;
						vr_q <= '0;
						idx_q <= '0;
						if (!kind) begin
							if (occ_q < CW'(QUEUE_DEPTH)) begin
								st_q <= mpq_pkg::ST_OK;
								occ_q <= occ_q + CW'(1);
							end else st_q <= mpq_pkg::ST_FULL;
							state_q <= S_OUT;
						end else if (occ_q == '0) begin
							st_q <= mpq_pkg::ST_EMPTY;
							state_q <= S_OUT;
						end else begin
							st_q <= mpq_pkg::ST_OK;
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: state_q <= S_SVR;
				S_SVR: begin
					vrd_ok_q <= tvalid(qrd_q.thread) && vr_valid_q[t_addr];
					state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (idx_q == '0 || key < bkey_q) begin
						bkey_q <= key;
						best_q <= idx_q[AW-1:0];
					end
					if (idx_q + CW'(1) < occ_q) begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_SRD;
					end else state_q <= S_GET;
				end
				S_GET: state_q <= S_GVR;
				S_GVR: begin
					sel_q <= qrd_q;
					state_q <= S_MUL;
				end
				S_MUL: begin
					vr_q <= (tvalid(sel_q.thread) && vr_valid_q[t_addr]) ? vrd_q : '0;
					add_q <= (VW+1)'({16'd0, sel_q.length}
						* {22'd0, 10'd7 + 10'd3 * {5'd0, sel_q.thread}});
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (tvalid(sel_q.thread)) vr_valid_q[t_addr] <= 1'b1;
					idx_q <= CW'(best_q) + CW'(1);
					state_q <= S_CRD;
				end
				S_CRD: begin
					if (idx_q < occ_q) state_q <= S_CWR;
					else begin
						occ_q <= occ_q - CW'(1);
						state_q <= S_OUT;
					end
				end
				S_CWR: begin
					idx_q <= idx_q + CW'(1);
					state_q <= S_CRD;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* tb/sv/multi_policy_ready_queue_scheduler_chk.sv */
// multi_policy_ready_queue_scheduler_chk: watches the input, config and result channels,
// predicts each result of the ready queue scheduler and compares field by field
// depends on mpq_pkg
module multi_policy_ready_queue_scheduler_chk (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic in_valid,
	input  logic in_stall,
	input  logic kind,
	input  logic [4:0] thread_id,
	input  logic [15:0] burst_index,
	input  logic [15:0] burst_length,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [1:0] status,
	input  logic [4:0] sel_thread,
	input  logic [15:0] sel_index,
	input  logic [15:0] sel_length,
	input  logic [47:0] sel_vruntime,
	output int pending,
	output int fail_count,
	output int beats_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		mpq_pkg::status_t st;
		logic [4:0] thread;
		logic [15:0] index;
		logic [15:0] length;
		logic [47:0] vr;
	} sched_result_t;

	mpq_pkg::entry_t ready_q[$];
	logic [mpq_pkg::VW-1:0] thread_vr[1:mpq_pkg::THREADS];
	mpq_pkg::policy_t cur_policy = mpq_pkg::POL_FCFS;
	sched_result_t expected_results[$];

	initial begin
		foreach (thread_vr[i]) thread_vr[i] = '0;
		pending = 0;
		fail_count = 0;
		beats_checked = 0;
	end

	function automatic logic [mpq_pkg::VW-1:0] vr_of_thread(logic [4:0] t);
		return (t >= 1 && t <= mpq_pkg::THREADS) ? thread_vr[t] : '0;
	endfunction

	function automatic logic [mpq_pkg::VW-1:0] sched_key(mpq_pkg::entry_t e);
		case (cur_policy)
			mpq_pkg::POL_FCFS: return '0;
			mpq_pkg::POL_SJF:  return mpq_pkg::VW'(e.length);
			mpq_pkg::POL_PRIO: return mpq_pkg::VW'(e.thread);
			default:           return vr_of_thread(e.thread);
		endcase
	endfunction

	function automatic sched_result_t schedule_beat(logic k, mpq_pkg::entry_t e);
		sched_result_t r;
		int best;
		logic [mpq_pkg::VW-1:0] best_key;
		logic [mpq_pkg::VW:0] sum;
		r = '{mpq_pkg::ST_OK, '0, '0, '0, '0};
		if (k == 1'b0) begin
			if (ready_q.size() >= mpq_pkg::QUEUE_DEPTH)
				r.st = mpq_pkg::ST_FULL;
			else
				ready_q.push_back(e);
			return r;
		end
		if (ready_q.size() == 0) begin
			r.st = mpq_pkg::ST_EMPTY;
			return r;
		end
		best = 0;
		best_key = sched_key(ready_q[0]);
		for (int i = 1; i < ready_q.size(); i++) begin
			if (sched_key(ready_q[i]) < best_key) begin
				best_key = sched_key(ready_q[i]);
				best = i;
			end
		end
		r.thread = ready_q[best].thread;
		r.index = ready_q[best].index;
		r.length = ready_q[best].length;
		r.vr = vr_of_thread(r.thread);
		ready_q.delete(best);
		if (r.thread >= 1 && r.thread <= mpq_pkg::THREADS) begin
			sum = {1'b0, r.vr} + (mpq_pkg::VW + 1)'(r.length)
				* (mpq_pkg::VW + 1)'(7 + 3 * r.thread);
			thread_vr[r.thread] = sum[mpq_pkg::VW] ? mpq_pkg::VR_MAX
				: sum[mpq_pkg::VW-1:0];
		end
		return r;
	endfunction

	task automatic report(string field, logic [47:0] got, logic [47:0] want);
		$display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, field, got, want);
		fail_count++;
	endtask

	always @(posedge clk) begin
		sched_result_t want;
		if (arst_n) begin
			if (cfg_we)
				cur_policy = mpq_pkg::policy_t'(cfg_wdata);
			if (in_valid && !in_stall)
				expected_results.push_back(schedule_beat(kind,
					'{thread: thread_id, index: burst_index, length: burst_length}));
			if (out_valid && !out_stall) begin
				beats_checked++;
				if (expected_results.size() == 0) begin
					report("unexpected result beat", '0, '0);
				end else begin
					want = expected_results.pop_front();
					if (status != want.st) report("status", status, want.st);
					if (sel_thread != want.thread) report("sel_thread", sel_thread, want.thread);
					if (sel_index != want.index) report("sel_index", sel_index, want.index);
					if (sel_length != want.length) report("sel_length", sel_length, want.length);
					if (sel_vruntime != want.vr) report("sel_vruntime", sel_vruntime, want.vr);
				end
			end
			pending = expected_results.size();
		end
	end
endmodule

/* tb/sv/multi_policy_ready_queue_scheduler_tb.sv */
// multi_policy_ready_queue_scheduler_tb: clock, reset, stimulus and verdict for the scheduler
// directed beats, then random fill/drain phases under every policy, with random stalls in all but the last
// depends on mpq_pkg, multi_policy_ready_queue_scheduler and multi_policy_ready_queue_scheduler_chk
module multi_policy_ready_queue_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic kind = 1'b0;
	logic [4:0] thread_id = '0;
	logic [15:0] burst_index = '0;
	logic [15:0] burst_length = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [4:0] sel_thread;
	logic [15:0] sel_index;
	logic [15:0] sel_length;
	logic [47:0] sel_vruntime;

	int pending;
	int fail_count;
	int beats_checked;
	int cycles = 0;
	int beats_sent = 0;
	bit quiet = 1'b0;
	bit hold_go = 1'b0;

	multi_policy_ready_queue_scheduler u_top (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .kind, .thread_id,
		.burst_index, .burst_length, .out_valid, .out_stall, .status, .sel_thread,
		.sel_index, .sel_length, .sel_vruntime
	);

	multi_policy_ready_queue_scheduler_chk u_chk (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_stall, .kind, .thread_id,
		.burst_index, .burst_length, .out_valid, .out_stall, .status, .sel_thread,
		.sel_index, .sel_length, .sel_vruntime, .pending, .fail_count, .beats_checked
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// result side stall: random bursts, one long hold on request
	initial begin
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (hold_go) begin
				hold_go = 1'b0;
				out_stall <= 1'b1;
				repeat (300) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
				@(negedge clk);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_beat(logic k, logic [4:0] t, logic [15:0] bi, logic [15:0] bl);
		bit stalled;
		in_valid <= 1'b1;
		kind <= k;
		thread_id <= t;
		burst_index <= bi;
		burst_length <= bl;
		beats_sent++;
		do begin
			#1 stalled = in_stall;
			@(negedge clk);
		end while (stalled);
	endtask

	task automatic idle(int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic set_policy(mpq_pkg::policy_t p);
		in_valid <= 1'b0;
		@(negedge clk);
		wait (pending == 0);
		repeat (12) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		mpq_pkg::policy_t phase_pol[8];
		logic k;
		logic [4:0] t;
		logic [15:0] bl;
		int mode;
		phase_pol = '{mpq_pkg::POL_FCFS, mpq_pkg::POL_VRT, mpq_pkg::POL_SJF,
			mpq_pkg::POL_PRIO, mpq_pkg::POL_VRT, mpq_pkg::POL_SJF, mpq_pkg::POL_PRIO,
			mpq_pkg::POL_FCFS};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty dispatch, field extremes, odd thread numbers
		send_beat(1'b1, 5'd3, 16'h1111, 16'h2222);
		send_beat(1'b0, 5'd1, 16'h0000, 16'h0000);
		send_beat(1'b0, 5'd16, 16'hffff, 16'hffff);
		send_beat(1'b0, 5'd0, 16'h1234, 16'h0005);
		send_beat(1'b0, 5'd31, 16'h5555, 16'haaaa);
		send_beat(1'b0, 5'd17, 16'haaaa, 16'h5555);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		set_policy(mpq_pkg::POL_SJF);
		send_beat(1'b0, 5'd16, 16'h0001, 16'h0003);
		send_beat(1'b0, 5'd2, 16'h0002, 16'h0003);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		set_policy(mpq_pkg::POL_PRIO);
		send_beat(1'b0, 5'd9, 16'h0003, 16'h0010);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		set_policy(mpq_pkg::POL_VRT);
		send_beat(1'b0, 5'd16, 16'h0004, 16'hffff);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);
		send_beat(1'b1, 5'd0, 16'h0, 16'h0);

		// random fill and drain phases, last phase without stalls
		for (int ph = 0; ph < 8; ph++) begin
			set_policy(phase_pol[ph]);
			quiet = (ph == 7);
			for (int n = 0; n < 116; n++) begin
				mode = (n / 29) % 4;
				case (mode)
					0, 3:    k = ($urandom_range(0, 99) < 15);
					1:       k = ($urandom_range(0, 99) < 75);
					default: k = $urandom_range(0, 1);
				endcase
				t = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
					: 5'($urandom_range(1, mpq_pkg::THREADS));
				bl = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
				if (ph == 2 && n == 40)
					hold_go = 1'b1;
				send_beat(k, t, 16'($urandom), bl);
				if (!quiet && $urandom_range(0, 4) == 0)
					idle($urandom_range(1, 18));
			end
		end

		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (100) @(negedge clk);
		$display("covered %0d beats and %0d results under all four policies,", beats_sent,
			beats_checked);
		$display("with full and empty queue, odd thread numbers, ties and long result stalls");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

/* files.f */
rtl/mpq_pkg.sv
rtl/multi_policy_ready_queue_scheduler.sv
tb/sv/multi_policy_ready_queue_scheduler_chk.sv
tb/sv/multi_policy_ready_queue_scheduler_tb.sv
